[design/svm_pkg.sv]
// Shared types and constants of the stereo voice mixer.
package svm_pkg;

    localparam int ADDR_W   = 12;
    localparam int LEN_W    = 13;
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 19;
    localparam int OPA_W    = 17;
    localparam int PROD_W   = 36;
    localparam int MAG_W    = 34;
    localparam int HI_W     = 19;
    localparam int FOLD_W   = 20;
    localparam int ACC_W    = 21;
    localparam int SEL_W    = 3;
    localparam int GIVEN_W  = 3;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;
    localparam logic [1:0] MODE_MIX   = 2'd3;

    localparam logic [15:0] DIV_K = 16'd32767;
    localparam logic signed [OPA_W-1:0] FULL_SCALE = 17'sd32767;
    localparam logic signed [ACC_W-1:0] ACC_HI = 21'sd32767;
    localparam logic signed [ACC_W-1:0] ACC_LO = -21'sd32768;

    typedef struct packed {
        logic latch;
        logic load_wr;
        logic stop_clr;
        logic fail;
        logic v_clear;
        logic v_inc;
        logic rd_voice;
        logic rd_sample;
        logic free_cur;
        logic op_gain;
        logic acc;
        logic claim;
    } svm_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       load_ok;
        logic       start_ok;
        logic       stop_ok;
        logic       v_active;
        logic       exhausted;
        logic       v_last;
    } svm_stat_t;

endpackage

[design/svm_ctrl.sv]
// Sequencer of the stereo voice mixer: walks each word through its steps.
module svm_ctrl
    import svm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  svm_stat_t stat,
    output svm_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_SCAN   = 12'b0000_0000_0100,
        S_MUL    = 12'b0000_0000_1000,
        S_ABS    = 12'b0000_0001_0000,
        S_FOLD   = 12'b0000_0010_0000,
        S_QUOT   = 12'b0000_0100_0000,
        S_CLAIM  = 12'b0000_1000_0000,
        S_VCHECK = 12'b0001_0000_0000,
        S_VTEST  = 12'b0010_0000_0000,
        S_ACC    = 12'b0100_0000_0000,
        S_REPLY  = 12'b1000_0000_0000
    } svm_state_t;

    svm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.mode)
                    MODE_LOAD:
                    begin
                        cmd.load_wr = 1'b1;
                        cmd.fail    = !stat.load_ok;
                        state_next  = S_REPLY;
                    end
                    MODE_STOP:
                    begin
                        cmd.stop_clr = 1'b1;
                        cmd.fail     = !stat.stop_ok;
                        state_next   = S_REPLY;
                    end
                    MODE_START:
                    begin
                        if (stat.start_ok)
                        begin
                            cmd.v_clear = 1'b1;
                            state_next  = S_SCAN;
                        end
                        else
                        begin
                            cmd.fail   = 1'b1;
                            state_next = S_REPLY;
                        end
                    end
                    MODE_MIX:
                    begin
                        cmd.v_clear = 1'b1;
                        state_next  = S_VCHECK;
                    end
                    default:
                    begin
                        state_next = S_REPLY;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (!stat.v_active)
                begin
                    state_next = S_MUL;
                end
                else if (stat.v_last)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.v_inc = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.op_gain = (stat.mode == MODE_START);
                state_next  = S_ABS;
            end
            S_ABS:
            begin
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                state_next = S_QUOT;
            end
            S_QUOT:
            begin
                state_next = (stat.mode == MODE_START) ? S_CLAIM : S_ACC;
            end
            S_CLAIM:
            begin
                cmd.claim  = 1'b1;
                state_next = S_REPLY;
            end
            S_VCHECK:
            begin
                if (stat.v_active)
                begin
                    cmd.rd_voice = 1'b1;
                    state_next   = S_VTEST;
                end
                else if (stat.v_last)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.v_inc = 1'b1;
                end
            end
            S_VTEST:
            begin
                if (stat.exhausted)
                begin
                    cmd.free_cur = 1'b1;
                    if (stat.v_last)
                    begin
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        cmd.v_inc  = 1'b1;
                        state_next = S_VCHECK;
                    end
                end
                else
                begin
                    cmd.rd_sample = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (stat.v_last)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.v_inc  = 1'b1;
                    state_next = S_VCHECK;
                end
            end
            S_REPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_REPLY);

endmodule

[design/svm_datapath.sv]
// Datapath of the stereo voice mixer: sample store, voice table and scaling lanes.
module svm_datapath
    import svm_pkg::*;
#(
    parameter int VOICES      = 8,
    parameter int STORE_DEPTH = 4096
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  svm_cmd_t                   cmd,
    output svm_stat_t                  stat,
    input  logic [1:0]                 mode,
    input  logic [ADDR_W-1:0]          address,
    input  logic signed [SAMPLE_W-1:0] sample_word,
    input  logic [LEN_W-1:0]           length,
    input  logic [15:0]                volume,
    input  logic signed [15:0]         pan,
    input  logic [SEL_W-1:0]           voice_select,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out,
    output logic                       status,
    output logic [GIVEN_W-1:0]         voice_given
);

    localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW  = (AW + 1 > LEN_W + 1) ? AW + 1 : LEN_W + 1;
    localparam int SCW = VW + 4;
    localparam int RW  = LEN_W + 1;

    logic [1:0]                 mode_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic signed [SAMPLE_W-1:0] word_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [15:0]                vol_reg;
    logic signed [15:0]         pan_reg;
    logic [SEL_W-1:0]           sel_reg;

    logic [SAMPLE_W-1:0]        store_mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [ADDR_W-1:0]          base_mem [VOICES];
    logic [LEN_W-1:0]           len_mem  [VOICES];
    logic [LEN_W-1:0]           pos_mem  [VOICES];
    logic signed [GAIN_W-1:0]   gl_mem   [VOICES];
    logic signed [GAIN_W-1:0]   gr_mem   [VOICES];

    logic [ADDR_W-1:0]          cur_base_reg;
    logic [LEN_W-1:0]           cur_len_reg;
    logic [LEN_W-1:0]           cur_pos_reg;
    logic signed [GAIN_W-1:0]   cur_gl_reg;
    logic signed [GAIN_W-1:0]   cur_gr_reg;

    logic [VOICES-1:0]          active_reg;
    logic [VW-1:0]              v_reg;

    logic signed [PROD_W-1:0]   prod_reg  [2];
    logic signed [PROD_W-1:0]   prod_next [2];
    logic [MAG_W-1:0]           mag_reg   [2];
    logic [MAG_W-1:0]           mag_next  [2];
    logic [HI_W-1:0]            hi_reg    [2];
    logic [HI_W-1:0]            hi_next   [2];
    logic [FOLD_W-1:0]          y1_reg    [2];
    logic [FOLD_W-1:0]          y1_next   [2];
    logic [HI_W-1:0]            qmag_reg  [2];
    logic [HI_W-1:0]            qmag_next [2];
    logic                       neg1_reg  [2];
    logic                       neg2_reg  [2];
    logic                       neg3_reg  [2];
    logic signed [SAMPLE_W-1:0] acc_reg   [2];
    logic signed [SAMPLE_W-1:0] acc_next  [2];

    logic signed [PROD_W-1:0]   abs_val   [2];
    logic [FOLD_W-16:0]         fold_hi   [2];
    logic [15:0]                fold_lo   [2];
    logic signed [ACC_W-1:0]    acc_sum   [2];
    logic signed [HI_W:0]       gain_wide [2];
    logic signed [GAIN_W-1:0]   gain_val  [2];

    logic signed [OPA_W-1:0]    op_a;
    logic signed [GAIN_W-1:0]   op_b [2];
    logic signed [OPA_W-1:0]    pan_ext;
    logic signed [OPA_W-1:0]    pan_left;
    logic signed [OPA_W-1:0]    pan_right;

    logic [SW-1:0]              fit_sum;
    logic                       load_ok;
    logic                       start_ok;
    logic                       sel_ok;
    logic                       stop_ok;
    logic [RW-1:0]              rd_sum;
    logic [LEN_W-1:0]           pos_inc;
    logic                       status_reg;
    logic [GIVEN_W-1:0]         given_reg;

    assign fit_sum  = SW'(addr_reg) + SW'(len_reg);
    assign load_ok  = SW'(addr_reg) < SW'(STORE_DEPTH);
    assign start_ok = (len_reg != '0) && (fit_sum <= SW'(STORE_DEPTH));
    assign sel_ok   = SCW'(sel_reg) < SCW'(VOICES);
    assign stop_ok  = sel_ok && active_reg[VW'(sel_reg)];
    assign rd_sum   = RW'(cur_base_reg) + RW'(cur_pos_reg);
    assign pos_inc  = cur_pos_reg + LEN_W'(1);

    assign stat.mode      = mode_reg;
    assign stat.load_ok   = load_ok;
    assign stat.start_ok  = start_ok;
    assign stat.stop_ok   = stop_ok;
    assign stat.v_active  = active_reg[v_reg];
    assign stat.exhausted = (cur_pos_reg >= cur_len_reg);
    assign stat.v_last    = (v_reg == VW'(VOICES - 1));

    always_ff @(posedge clk) begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            addr_reg <= address;
            word_reg <= sample_word;
            len_reg  <= length;
            vol_reg  <= volume;
            pan_reg  <= pan;
            sel_reg  <= voice_select;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_wr && load_ok)
        begin
            store_mem[AW'(addr_reg)] <= word_reg;
        end
        if (cmd.rd_sample)
        begin
            sample_reg <= $signed(store_mem[AW'(rd_sum)]);
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.claim)
        begin
            base_mem[v_reg] <= addr_reg;
            len_mem[v_reg]  <= len_reg;
            pos_mem[v_reg]  <= '0;
            gl_mem[v_reg]   <= gain_val[0];
            gr_mem[v_reg]   <= gain_val[1];
        end
        if (cmd.rd_sample)
        begin
            pos_mem[v_reg] <= pos_inc;
        end
        if (cmd.rd_voice)
        begin
            cur_base_reg <= base_mem[v_reg];
            cur_len_reg  <= len_mem[v_reg];
            cur_pos_reg  <= pos_mem[v_reg];
            cur_gl_reg   <= gl_mem[v_reg];
            cur_gr_reg   <= gr_mem[v_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            active_reg <= '0;
            v_reg      <= '0;
        end
        else
        begin
            if (cmd.claim)
            begin
                active_reg[v_reg] <= 1'b1;
            end
            if (cmd.stop_clr && stop_ok)
            begin
                active_reg[VW'(sel_reg)] <= 1'b0;
            end
            if (cmd.free_cur || (cmd.rd_sample && (pos_inc >= cur_len_reg)))
            begin
                active_reg[v_reg] <= 1'b0;
            end
            if (cmd.v_clear)
            begin
                v_reg <= '0;
            end
            else if (cmd.v_inc)
            begin
                v_reg <= v_reg + VW'(1);
            end
        end
    end

    always_comb begin
        pan_ext   = $signed({pan_reg[15], pan_reg});
        pan_left  = FULL_SCALE - pan_ext;
        pan_right = FULL_SCALE + pan_ext;
        op_a      = cmd.op_gain ? $signed({1'b0, vol_reg})
                                : $signed({sample_reg[15], sample_reg});
        op_b[0]   = cmd.op_gain ? $signed({{2{pan_left[OPA_W-1]}}, pan_left}) : cur_gl_reg;
        op_b[1]   = cmd.op_gain ? $signed({{2{pan_right[OPA_W-1]}}, pan_right}) : cur_gr_reg;
        for (int ch = 0; ch < 2; ch++)
        begin
            prod_next[ch] = op_a * op_b[ch];
            abs_val[ch]   = prod_reg[ch][PROD_W-1] ? -prod_reg[ch] : prod_reg[ch];
            mag_next[ch]  = abs_val[ch][MAG_W-1:0];
            hi_next[ch]   = mag_reg[ch][MAG_W-1:15];
            y1_next[ch]   = FOLD_W'(hi_next[ch]) + FOLD_W'(mag_reg[ch][14:0]);
            fold_hi[ch]   = y1_reg[ch][FOLD_W-1:15];
            fold_lo[ch]   = 16'(fold_hi[ch]) + 16'(y1_reg[ch][14:0]);
            qmag_next[ch] = hi_reg[ch] + HI_W'(fold_hi[ch]) + HI_W'(fold_lo[ch] >= DIV_K);
            acc_sum[ch]   = neg3_reg[ch]
                ? $signed({{5{acc_reg[ch][15]}}, acc_reg[ch]}) - $signed({2'b00, qmag_reg[ch]})
                : $signed({{5{acc_reg[ch][15]}}, acc_reg[ch]}) + $signed({2'b00, qmag_reg[ch]});
            if (acc_sum[ch] > ACC_HI)
            begin
                acc_next[ch] = ACC_HI[SAMPLE_W-1:0];
            end
            else if (acc_sum[ch] < ACC_LO)
            begin
                acc_next[ch] = ACC_LO[SAMPLE_W-1:0];
            end
            else
            begin
                acc_next[ch] = acc_sum[ch][SAMPLE_W-1:0];
            end
            gain_wide[ch] = neg3_reg[ch] ? -$signed({1'b0, qmag_reg[ch]})
                                         : $signed({1'b0, qmag_reg[ch]});
            gain_val[ch]  = gain_wide[ch][GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk) begin
        for (int ch = 0; ch < 2; ch++)
        begin
            prod_reg[ch] <= prod_next[ch];
            mag_reg[ch]  <= mag_next[ch];
            neg1_reg[ch] <= prod_reg[ch][PROD_W-1];
            hi_reg[ch]   <= hi_next[ch];
            y1_reg[ch]   <= y1_next[ch];
            neg2_reg[ch] <= neg1_reg[ch];
            qmag_reg[ch] <= qmag_next[ch];
            neg3_reg[ch] <= neg2_reg[ch];
            if (cmd.latch)
            begin
                acc_reg[ch] <= '0;
            end
            else if (cmd.acc)
            begin
                acc_reg[ch] <= acc_next[ch];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.latch)
        begin
            status_reg <= 1'b0;
            given_reg  <= '0;
        end
        else
        begin
            if (cmd.fail)
            begin
                status_reg <= 1'b1;
            end
            if (cmd.claim)
            begin
                given_reg <= GIVEN_W'(v_reg);
            end
        end
    end

    assign left_out    = acc_reg[0];
    assign right_out   = acc_reg[1];
    assign status      = status_reg;
    assign voice_given = given_reg;

endmodule

[design/stereo_voice_mixer.sv]
// Stereo voice mixer: voice table with pan and volume, mixing mono samples into stereo frames.
//
// Drive a word with start while busy is low; busy rises on the next cycle and the single
// result stands on left_out, right_out, status and voice_given while done is high for exactly
// one cycle, then busy falls. The result cannot be held off. A load or stop word is answered
// straight from its decode. A start word scans the voice table for a free voice, then sends
// its volume and pan gains through the chain and claims the voice; one refused for its length
// or range, or one that finds every voice busy, gets no voice. A mix word sends each voice
// that plays a sample in the frame through the chain. The chain is the shared multiply and
// divide-by-32767 chain (multiply, magnitude, two folds) that each voice, and each start's gain,
// walks through in turn. The voice table is scanned one voice per cycle while no voice is in
// the chain, and the voice table and the sample store are read through registers.
module stereo_voice_mixer
    import svm_pkg::*;
#(
    parameter int VOICES      = 8,
    parameter int STORE_DEPTH = 4096
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 mode,
    input  logic [ADDR_W-1:0]          address,
    input  logic signed [SAMPLE_W-1:0] sample_word,
    input  logic [LEN_W-1:0]           length,
    input  logic [15:0]                volume,
    input  logic signed [15:0]         pan,
    input  logic [SEL_W-1:0]           voice_select,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out,
    output logic                       status,
    output logic [GIVEN_W-1:0]         voice_given
);

    svm_cmd_t  cmd;
    svm_stat_t stat;

    svm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    svm_datapath #(
        .VOICES      (VOICES),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .address      (address),
        .sample_word  (sample_word),
        .length       (length),
        .volume       (volume),
        .pan          (pan),
        .voice_select (voice_select),
        .left_out     (left_out),
        .right_out    (right_out),
        .status       (status),
        .voice_given  (voice_given)
    );

endmodule

[design/svm_checker.sv]
// Port-level checks of the stereo voice mixer and their binding to the top level.
module svm_checker
    import svm_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [1:0]                 mode,
    input logic                       done,
    input logic signed [SAMPLE_W-1:0] left_out,
    input logic signed [SAMPLE_W-1:0] right_out,
    input logic                       status,
    input logic [GIVEN_W-1:0]         voice_given
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("done not followed by release of busy");

    a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode == MODE_LOAD || mode == MODE_STOP) |=> ##1 done)
        else $error("load or stop word not answered in two cycles");

    a_claim_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && voice_given != '0 |-> !status && left_out == '0 && right_out == '0)
        else $error("claimed voice with failure or nonzero samples");

    a_fail_no_voice: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> voice_given == '0)
        else $error("failure reported with a voice number");

endmodule

bind stereo_voice_mixer svm_checker u_svm_checker (.*);
